@@ hdl/assert_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is active.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

@@ hdl/rtsp_tok_pkg.sv @@
// Types, codes and constants of the RTSP request header tokenizer.
package rtsp_tok_pkg;

    // Parser phase, one-hot.
    typedef enum logic [5:0] {
        PH_METHOD    = 6'b000001,
        PH_URI       = 6'b000010,
        PH_VERSION   = 6'b000100,
        PH_NAME      = 6'b001000,
        PH_CSEQ_VAL  = 6'b010000,
        PH_OTHER_VAL = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DELIM = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        NUM_LEAD  = 2'd0,
        NUM_DIGIT = 2'd1,
        NUM_STOP  = 2'd2
    } num_phase_t;

    localparam logic [2:0] PART_METHOD  = 3'd0;
    localparam logic [2:0] PART_URI     = 3'd1;
    localparam logic [2:0] PART_VERSION = 3'd2;
    localparam logic [2:0] PART_NAME    = 3'd3;
    localparam logic [2:0] PART_VALUE   = 3'd4;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;

    localparam logic [7:0] SEP_RESET   = 8'd32;
    localparam logic [2:0] CSEQ_LENGTH = 3'd4;

    // Per-token matcher and number converter context.
    typedef struct packed {
        logic [2:0]  match_count;
        logic        mismatch;
        num_phase_t  num_phase;
        logic        negative;
        logic [31:0] accum;
    } token_ctx_t;

    localparam token_ctx_t CTX_CLEAR = '{
        match_count: 3'd0, mismatch: 1'b0, num_phase: NUM_LEAD,
        negative: 1'b0, accum: 32'd0
    };

    // Header name "CSeq", exact case.
    function automatic logic [7:0] cseq_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'd67;
            2'd1:    c = 8'd83;
            2'd2:    c = 8'd101;
            default: c = 8'd113;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/rtsp_tok_release.sv @@
// Byte release unit: header name matcher and CSeq value converter.
module rtsp_tok_release (
    input  rtsp_tok_pkg::phase_t     phase,
    input  logic [7:0]               rel_byte,
    input  rtsp_tok_pkg::token_ctx_t ctx_in,
    output rtsp_tok_pkg::token_ctx_t ctx_out
);
    import rtsp_tok_pkg::*;

    logic        is_digit;
    logic        is_space;
    logic [31:0] digit_val;
    logic [31:0] accum_x10;

    assign is_digit  = (rel_byte >= CH_ZERO) && (rel_byte <= CH_NINE);
    assign is_space  = (rel_byte == CH_SPACE) || ((rel_byte >= CH_TAB) && (rel_byte <= CH_CR));
    assign digit_val = {28'd0, rel_byte[3:0]};
    // x10 as shift-add, wraps mod 2^32
    assign accum_x10 = (ctx_in.accum << 3) + (ctx_in.accum << 1);

    always_comb begin
        ctx_out = ctx_in;
        if (phase == PH_NAME) begin
            if ((ctx_in.match_count < CSEQ_LENGTH) &&
                (rel_byte == cseq_char(ctx_in.match_count[1:0]))) begin
                ctx_out.match_count = ctx_in.match_count + 3'd1;
            end else begin
                ctx_out.mismatch = 1'b1;
            end
        end else if (phase == PH_CSEQ_VAL) begin
            case (ctx_in.num_phase)
                NUM_LEAD: begin
                    if (is_space) begin
                        ctx_out.num_phase = NUM_LEAD;
                    end else if ((rel_byte == CH_PLUS) || (rel_byte == CH_MINUS)) begin
                        ctx_out.negative  = (rel_byte == CH_MINUS);
                        ctx_out.num_phase = NUM_DIGIT;
                    end else if (is_digit) begin
                        ctx_out.accum     = digit_val;
                        ctx_out.num_phase = NUM_DIGIT;
                    end else begin
                        ctx_out.num_phase = NUM_STOP;
                    end
                end
                NUM_DIGIT: begin
                    if (is_digit) begin
                        ctx_out.accum = accum_x10 + digit_val;
                    end else begin
                        ctx_out.num_phase = NUM_STOP;
                    end
                end
                default: ctx_out.num_phase = ctx_in.num_phase;
            endcase
        end
    end

endmodule

@@ hdl/rtsp_request_header_tokenizer.sv @@
// A result is registered, and shown in the cycle after its input transaction is accepted.
// Throughput: one byte per cycle while m_ready drains the result register; the whole per-byte
//   update is a single combinational pass from the state registers into the result register.
// Reset: synchronous, active low; parser returns to the method phase, the
//   separator register to 32 (space), output register empties.
// One result transaction for every input transaction.
module rtsp_request_header_tokenizer (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_token_separator,
    // request byte stream
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    // result stream
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_emit_valid,
    output logic [7:0]         m_token_byte,
    output logic [2:0]         m_part,
    output logic               m_token_end,
    output logic               m_ended_by_separator,
    output logic               m_message_done,
    output logic [1:0]         m_error_code,
    output logic signed [31:0] m_cseq_value
);
    import rtsp_tok_pkg::*;
    `include "assert_macros.svh"

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [7:0]  sep_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic        at_start_reg, at_start_next;
    logic        skip_reg, skip_next;
    token_ctx_t  ctx_reg, ctx_next, ctx_rel;
    token_ctx_t  ctx_fin;
    logic [31:0] seq_reg, seq_next;

    // output register
    logic        m_valid_reg;
    logic        emit_reg, emit_next;
    logic [7:0]  tbyte_reg, tbyte_next;
    logic [2:0]  part_reg, part_next;
    logic        tend_reg, tend_next;
    logic        bysep_reg, bysep_next;
    logic        done_reg, done_next;
    err_t        err_reg, err_next;
    logic [31:0] seq_out_reg, seq_out_next;

    logic in_accept;
    logic is_sep;
    logic is_delim;
    logic release_now;
    logic empty_tok;
    logic restart;

    // The user must write config only while idle; the block does not enforce this and is always ready.
    assign cfg_ready = 1'b1;

    // Take a new byte whenever the result register is free or being drained.
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    // Separator is checked first, so a separator equal to CR or LF counts as separator.
    assign is_sep   = (s_in_byte == sep_reg);
    assign is_delim = is_sep || (s_in_byte == CH_CR) || (s_in_byte == CH_LF);

    // Held byte leaves the one-byte delay stage; a trailing colon is dropped at a delimiter.
    always_comb begin
        if (skip_reg && is_delim) begin
            release_now = 1'b0;
        end else if (!is_delim) begin
            release_now = held_valid_reg;
        end else begin
            release_now = held_valid_reg && (held_byte_reg != CH_COLON);
        end
    end

    rtsp_tok_release u_release (
        .phase    (phase_reg),
        .rel_byte (held_byte_reg),
        .ctx_in   (ctx_reg),
        .ctx_out  (ctx_rel)
    );

    // Token context after this byte: a trimmed colon never reaches the matcher.
    assign ctx_fin = release_now ? ctx_rel : ctx_reg;

    // Empty when nothing was released for this token, counting this byte.
    assign empty_tok = at_start_reg && !release_now;

    // ------------------------------------------------------------------
    // Per-byte update
    // ------------------------------------------------------------------
    always_comb begin
        phase_next      = phase_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        at_start_next   = at_start_reg;
        skip_next       = 1'b0;
        ctx_next        = ctx_reg;
        seq_next        = seq_reg;
        restart         = 1'b0;

        emit_next    = release_now;
        tbyte_next   = release_now ? held_byte_reg : 8'd0;
        tend_next    = 1'b0;
        bysep_next   = 1'b0;
        done_next    = 1'b0;
        err_next     = ERR_NONE;
        seq_out_next = seq_reg;

        unique case (phase_reg)
            PH_URI:       part_next = PART_URI;
            PH_VERSION:   part_next = PART_VERSION;
            PH_NAME:      part_next = PART_NAME;
            PH_CSEQ_VAL:  part_next = PART_VALUE;
            PH_OTHER_VAL: part_next = PART_VALUE;
            default:      part_next = PART_METHOD;
        endcase

        if (skip_reg && is_delim) begin
            // swallowed delimiter: state kept, only the skip flag drops
        end else if (!is_delim) begin
            if (release_now) begin
                ctx_next      = ctx_rel;
                at_start_next = 1'b0;
            end
            held_byte_next  = s_in_byte;
            held_valid_next = 1'b1;
        end else begin
            tend_next  = 1'b1;
            bysep_next = is_sep;
            if (empty_tok) begin
                if (phase_reg == PH_NAME) begin
                    done_next = 1'b1;
                end else begin
                    err_next = ERR_EMPTY;
                end
                restart = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_URI: begin
                        if (is_sep) phase_next = PH_VERSION;
                        else begin
                            err_next = ERR_DELIM;
                            restart  = 1'b1;
                        end
                    end
                    PH_VERSION: begin
                        if (!is_sep) phase_next = PH_NAME;
                        else begin
                            err_next = ERR_DELIM;
                            restart  = 1'b1;
                        end
                    end
                    PH_NAME: begin
                        // matcher result includes the byte released just now
                        if (is_sep) begin
                            phase_next = (!ctx_fin.mismatch && ctx_fin.match_count == CSEQ_LENGTH)
                                       ? PH_CSEQ_VAL : PH_OTHER_VAL;
                        end else begin
                            err_next = ERR_DELIM;
                            restart  = 1'b1;
                        end
                    end
                    PH_CSEQ_VAL: begin
                        if (!is_sep) begin
                            seq_next     = ctx_fin.negative ? (~ctx_fin.accum + 32'd1)
                                                            : ctx_fin.accum;
                            seq_out_next = seq_next;
                            phase_next   = PH_NAME;
                        end else begin
                            err_next = ERR_DELIM;
                            restart  = 1'b1;
                        end
                    end
                    PH_OTHER_VAL: begin
                        phase_next = is_sep ? PH_OTHER_VAL : PH_NAME;
                    end
                    default: begin
                        // method, and any stray code treated as method
                        if (is_sep) phase_next = PH_URI;
                        else begin
                            err_next = ERR_DELIM;
                            restart  = 1'b1;
                        end
                    end
                endcase
            end
            if (restart) begin
                // CSeq cleared after this transaction's output
                phase_next = PH_METHOD;
                seq_next   = 32'd0;
            end
            held_byte_next  = 8'd0;
            held_valid_next = 1'b0;
            at_start_next   = 1'b1;
            ctx_next        = CTX_CLEAR;
            skip_next       = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg        <= SEP_RESET;
            phase_reg      <= PH_METHOD;
            held_byte_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            at_start_reg   <= 1'b1;
            skip_reg       <= 1'b0;
            ctx_reg        <= CTX_CLEAR;
            seq_reg        <= 32'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                sep_reg <= cfg_token_separator;
            end
            if (in_accept) begin
                phase_reg      <= phase_next;
                held_byte_reg  <= held_byte_next;
                held_valid_reg <= held_valid_next;
                at_start_reg   <= at_start_next;
                skip_reg       <= skip_next;
                ctx_reg        <= ctx_next;
                seq_reg        <= seq_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted transaction
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            emit_reg    <= emit_next;
            tbyte_reg   <= tbyte_next;
            part_reg    <= part_next;
            tend_reg    <= tend_next;
            bysep_reg   <= bysep_next;
            done_reg    <= done_next;
            err_reg     <= err_next;
            seq_out_reg <= seq_out_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_emit_valid         = emit_reg;
    assign m_token_byte         = tbyte_reg;
    assign m_part               = part_reg;
    assign m_token_end          = tend_reg;
    assign m_ended_by_separator = bysep_reg;
    assign m_message_done       = done_reg;
    assign m_error_code         = err_reg;
    assign m_cseq_value         = $signed(seq_out_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_accept_fills_out, aclk, aresetn, (s_valid && s_ready) |=> m_valid, "accepted transaction produced no result")
    `ASSERT_CLK(a_ready_when_empty, aclk, aresetn, !m_valid |-> s_ready, "input stalled with empty output register")
    `ASSERT_CLK(a_done_is_clean_end, aclk, aresetn, (m_valid && m_message_done) |-> (m_token_end && m_error_code == ERR_NONE), "message_done without clean token end")
    `ASSERT_NEVER(a_sep_needs_end, aclk, aresetn, m_valid && m_ended_by_separator && !m_token_end, "separator flag without token end")

endmodule
